/* src/fmtf_pkg.sv */
// Shared types, sizes and helpers for the move-to-front queue.
package fmtf_pkg;

    localparam int DEPTH         = 16;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int COUNT_FIELD_W = 5;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_MTF = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_DEQ_WAIT,
        S_SEARCH,
        S_SHIFT,
        S_PLACE,
        S_FINISH
    } state_t;

    // Write port of the entry store.
    typedef struct packed {
        logic  en;
        addr_t addr;
        data_t data;
    } wr_t;

    // One result word, before packing onto the stream.
    typedef struct packed {
        data_t                    front_value;
        logic                     is_empty;
        logic [COUNT_FIELD_W-1:0] entry_count;
        logic                     key_found;
        status_t                  status;
    } res_t;

    // Ring address: base plus offset, both below DEPTH, folded back once.
    function automatic addr_t wrap_addr(addr_t base, addr_t offset);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (ADDR_W + 1)'(DEPTH))
        begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // The count as reported: its low five bits.
    function automatic logic [COUNT_FIELD_W-1:0] count_field(cnt_t c);
        logic [CNT_W+COUNT_FIELD_W-1:0] wide;
        wide = {{COUNT_FIELD_W{1'b0}}, c};
        return wide[COUNT_FIELD_W-1:0];
    endfunction

endpackage

/* src/fmtf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module fmtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/fmtf_seq.sv */
// Sequencer and shared compare unit that run one command over the ring store.
module fmtf_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  fmtf_pkg::cmd_t        in_cmd,
    input  fmtf_pkg::data_t       in_key,
    output logic                  in_ready,
    input  logic                  out_free,
    output logic                  res_valid,
    output fmtf_pkg::res_t        res,
    output fmtf_pkg::wr_t         ram_wr,
    output fmtf_pkg::addr_t       ram_raddr,
    input  fmtf_pkg::data_t       ram_rdata
);

    fmtf_pkg::state_t  state_reg,  state_next;
    fmtf_pkg::addr_t   head_reg,   head_next;
    fmtf_pkg::cnt_t    count_reg,  count_next;
    fmtf_pkg::data_t   front_reg,  front_next;
    fmtf_pkg::cmd_t    cmd_reg,    cmd_next;
    fmtf_pkg::data_t   key_reg,    key_next;
    fmtf_pkg::addr_t   pos_reg,    pos_next;
    logic              found_reg,  found_next;
    fmtf_pkg::status_t status_reg, status_next;

    logic key_match;
    logic search_last;

    // The one comparator, fed by the entry read in the previous cycle.
    assign key_match   = (ram_rdata == key_reg);
    assign search_last = ((fmtf_pkg::CNT_W)'(pos_reg) + (fmtf_pkg::CNT_W)'(1)) >= count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmtf_pkg::S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg  <= front_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fmtf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fmtf_pkg::S_DISPATCH;
                end
            end
            fmtf_pkg::S_DISPATCH:
            begin
                unique case (cmd_reg)
                    fmtf_pkg::CMD_ENQ: state_next = fmtf_pkg::S_FINISH;
                    fmtf_pkg::CMD_DEQ:
                    begin
                        state_next = (count_reg > (fmtf_pkg::CNT_W)'(1))
                                     ? fmtf_pkg::S_DEQ_WAIT : fmtf_pkg::S_FINISH;
                    end
                    fmtf_pkg::CMD_MTF:
                    begin
                        state_next = (count_reg >= (fmtf_pkg::CNT_W)'(2))
                                     ? fmtf_pkg::S_SEARCH : fmtf_pkg::S_FINISH;
                    end
                    default: state_next = fmtf_pkg::S_FINISH;
                endcase
            end
            fmtf_pkg::S_DEQ_WAIT: state_next = fmtf_pkg::S_FINISH;
            fmtf_pkg::S_SEARCH:
            begin
                priority if (key_match)
                begin
                    state_next = fmtf_pkg::S_SHIFT;
                end
                else if (search_last)
                begin
                    state_next = fmtf_pkg::S_FINISH;
                end
                else
                begin
                    state_next = fmtf_pkg::S_SEARCH;
                end
            end
            fmtf_pkg::S_SHIFT:
            begin
                if (pos_reg == (fmtf_pkg::ADDR_W)'(1))
                begin
                    state_next = fmtf_pkg::S_PLACE;
                end
            end
            fmtf_pkg::S_PLACE: state_next = fmtf_pkg::S_FINISH;
            fmtf_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = fmtf_pkg::S_IDLE;
                end
            end
            default: state_next = fmtf_pkg::S_IDLE;
        endcase
    end

    // Datapath, store port and pointer updates.
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        front_next  = front_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        status_next = status_reg;
        ram_wr      = '0;
        ram_raddr   = fmtf_pkg::wrap_addr(head_reg, (fmtf_pkg::ADDR_W)'(1));

        unique case (state_reg)
            fmtf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = in_cmd;
                    key_next    = in_key;
                    found_next  = 1'b0;
                    status_next = fmtf_pkg::ST_OK;
                end
            end
            fmtf_pkg::S_DISPATCH:
            begin
                unique case (cmd_reg)
                    fmtf_pkg::CMD_ENQ:
                    begin
                        if (count_reg == (fmtf_pkg::CNT_W)'(fmtf_pkg::DEPTH))
                        begin
                            status_next = fmtf_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_wr.en   = 1'b1;
                            ram_wr.addr = fmtf_pkg::wrap_addr(head_reg,
                                              (fmtf_pkg::ADDR_W)'(count_reg));
                            ram_wr.data = key_reg;
                            count_next  = count_reg + (fmtf_pkg::CNT_W)'(1);
                            if (count_reg == '0)
                            begin
                                front_next = key_reg;
                            end
                        end
                    end
                    fmtf_pkg::CMD_DEQ:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = fmtf_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            // The second entry becomes the front; it is read here.
                            count_next = count_reg - (fmtf_pkg::CNT_W)'(1);
                            head_next  = fmtf_pkg::wrap_addr(head_reg,
                                             (fmtf_pkg::ADDR_W)'(1));
                        end
                    end
                    fmtf_pkg::CMD_MTF:
                    begin
                        pos_next = (fmtf_pkg::ADDR_W)'(1);
                    end
                    default:
                    begin
                        status_next = fmtf_pkg::ST_OK;
                    end
                endcase
            end
            fmtf_pkg::S_DEQ_WAIT:
            begin
                front_next = ram_rdata;
            end
            fmtf_pkg::S_SEARCH:
            begin
                if (key_match)
                begin
                    // Start the shift with the entry just ahead of the match.
                    ram_raddr = fmtf_pkg::wrap_addr(head_reg,
                                    pos_reg - (fmtf_pkg::ADDR_W)'(1));
                end
                else
                begin
                    ram_raddr = fmtf_pkg::wrap_addr(head_reg,
                                    pos_reg + (fmtf_pkg::ADDR_W)'(1));
                    if (!search_last)
                    begin
                        pos_next = pos_reg + (fmtf_pkg::ADDR_W)'(1);
                    end
                end
            end
            fmtf_pkg::S_SHIFT:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = fmtf_pkg::wrap_addr(head_reg, pos_reg);
                ram_wr.data = ram_rdata;
                ram_raddr   = fmtf_pkg::wrap_addr(head_reg,
                                  pos_reg - (fmtf_pkg::ADDR_W)'(2));
                pos_next    = pos_reg - (fmtf_pkg::ADDR_W)'(1);
            end
            fmtf_pkg::S_PLACE:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = head_reg;
                ram_wr.data = key_reg;
                front_next  = key_reg;
                found_next  = 1'b1;
            end
            fmtf_pkg::S_FINISH:
            begin
                found_next = found_reg;
            end
            default:
            begin
                found_next = found_reg;
            end
        endcase
    end

    // Handshake and result outputs.
    always_comb
    begin
        in_ready        = (state_reg == fmtf_pkg::S_IDLE);
        res_valid       = (state_reg == fmtf_pkg::S_FINISH);
        res.front_value = (count_reg != '0) ? front_reg : '0;
        res.is_empty    = (count_reg == '0);
        res.entry_count = fmtf_pkg::count_field(count_reg);
        res.key_found   = found_reg;
        res.status      = status_reg;
    end

endmodule

/* src/fifo_with_move_to_front.sv */
// Top level of the bounded queue with a move-to-front search.
//
//  Channel   Direction  tdata / tuser contents (lowest bit first)
//  s_axis    in         tdata: value[31:0]; tuser: command[1:0]
//  m_axis    out        tdata: front_value[31:0], is_empty[32], entry_count[37:33],
//                              key_found[38], status[40:39], zero[47:41]
//
// One command word is worked at a time. The sequencer holds the entries in a
// ring memory with one write and one registered read port, and a single
// comparator checks one stored entry per cycle. Each command is registered on
// acceptance and dispatched; a dequeue that leaves entries behind then reads
// its new front, and a move to front searches from the second entry on. On a
// match the entries ahead of it shift back by one, and the key is written at
// the front. The result is then offered until the output register is free.
// The input is ready again the cycle after the result is loaded, even while
// that result still waits in the output register. Reset empties the queue at
// once; the stored entries are not cleared, as empty slots are never used.
module fifo_with_move_to_front (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // front_value, is_empty, entry_count,
                                        // key_found, status, zero fill
);

    fmtf_pkg::wr_t   ram_wr;
    fmtf_pkg::addr_t ram_raddr;
    fmtf_pkg::data_t ram_rdata;
    fmtf_pkg::res_t  res;
    logic            res_valid;
    logic            out_free;
    logic            m_valid_reg;
    logic            m_valid_next;
    fmtf_pkg::res_t  res_reg;

    // The output register frees up as soon as the word it holds is taken.
    assign out_free = !m_valid_reg || m_axis_tready;

    fmtf_ram #(
        .WIDTH (fmtf_pkg::DATA_W),
        .DEPTH (fmtf_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_wr.en),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fmtf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (fmtf_pkg::cmd_t'(s_axis_tuser)),
        .in_key    (fmtf_pkg::data_t'(s_axis_tdata)),
        .in_ready  (s_axis_tready),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_wr    (ram_wr),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // The sequencer only leaves its finish state when out_free is high, so a
    // result offered here is always loaded.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        priority if (res_valid && out_free)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, res_reg.status, res_reg.key_found,
                            res_reg.entry_count, res_reg.is_empty,
                            res_reg.front_value};

endmodule

/* bench/fifo_with_move_to_front_tb.sv */
// Self-checking testbench for the move-to-front queue: directed steps, then random traffic.
module fifo_with_move_to_front_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Command code 3 means nothing to the block, but it still answers with one word.
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam int WORD_GOAL    = 1850;          // random commands that do real work
    localparam int QUIET_TAIL   = 150;           // last commands run with no idling at all
    localparam int PHASE_LEN    = 40;            // commands between changes of traffic mix
    localparam int DRAIN_CYCLES = 2 * fmtf_pkg::DEPTH + 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_SHOWN    = 10;

    // One row of the directed table. Rows with a typed result carry it in want; the
    // others are checked against the queue model.
    typedef struct {
        logic [1:0]      cmd;
        fmtf_pkg::data_t value;
        bit              typed;
        fmtf_pkg::res_t  want;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    fmtf_pkg::data_t held_q[$];       // model of the queue contents, front at index 0
    fmtf_pkg::res_t  owed_q[$];       // result words the block still owes, oldest first
    step_t           dir_steps[$];

    int fault_count = 0;
    int cycles      = 0;
    bit rx_stall_on = 1'b0; // when set, the result side stalls in random bursts

    fifo_with_move_to_front DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Hard stop in case the block hangs or loses a word.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("fifo_with_move_to_front regression: fail");
            $finish;
        end
    end

    // Queue model: applies one command to held_q and returns the word the block
    // should answer with. A move searches from the second entry on and takes the
    // first match, so a key that sits only at the front is left alone.
    function automatic fmtf_pkg::res_t apply_command(logic [1:0] cmd, fmtf_pkg::data_t val);
        fmtf_pkg::res_t r;
        int             hit;
        int             i;
        r           = '0;
        r.status    = fmtf_pkg::ST_OK;
        r.key_found = 1'b0;
        hit         = -1;
        if (cmd == fmtf_pkg::CMD_ENQ)
        begin
            if (held_q.size() >= fmtf_pkg::DEPTH)
            begin
                r.status = fmtf_pkg::ST_FULL;
            end
            else
            begin
                held_q.push_back(val);
            end
        end
        else if (cmd == fmtf_pkg::CMD_DEQ)
        begin
            if (held_q.size() == 0)
            begin
                r.status = fmtf_pkg::ST_EMPTY;
            end
            else
            begin
                void'(held_q.pop_front());
            end
        end
        else if (cmd == fmtf_pkg::CMD_MTF && held_q.size() >= 2)
        begin
            for (i = 1; i < held_q.size() && hit < 0; i++)
            begin
                if (held_q[i] == val)
                begin
                    hit = i;
                end
            end
            if (hit > 0)
            begin
                held_q.delete(hit);
                held_q.push_front(val);
                r.key_found = 1'b1;
            end
        end
        r.front_value = (held_q.size() > 0) ? held_q[0] : fmtf_pkg::data_t'(0);
        r.is_empty    = (held_q.size() == 0);
        r.entry_count = fmtf_pkg::COUNT_FIELD_W'(held_q.size());
        return r;
    endfunction

    // Result word as it appears on m_axis_tdata, zero fill included.
    function automatic logic [47:0] word_of(fmtf_pkg::res_t r);
        return {7'b0, r.status, r.key_found, r.entry_count, r.is_empty, r.front_value};
    endfunction

    function automatic fmtf_pkg::res_t result_of(fmtf_pkg::data_t front, bit empty,
                                                 int count, bit found,
                                                 fmtf_pkg::status_t st);
        fmtf_pkg::res_t r;
        r.front_value = front;
        r.is_empty    = empty;
        r.entry_count = count[fmtf_pkg::COUNT_FIELD_W-1:0];
        r.key_found   = found;
        r.status      = st;
        return r;
    endfunction

    function automatic void add_step(logic [1:0] cmd, fmtf_pkg::data_t value, bit typed,
                                     fmtf_pkg::res_t want);
        step_t s;
        s.cmd   = cmd;
        s.value = value;
        s.typed = typed;
        s.want  = want;
        dir_steps.push_back(s);
    endfunction

    function automatic void flag_fault(string what, logic [47:0] want, logic [47:0] got);
        fault_count++;
        if (fault_count <= MAX_SHOWN)
        begin
            $display("%0t ns %s: expected front=%h empty=%b count=%0d found=%b status=%0d",
                     $realtime, what, want[31:0], want[32], want[37:33], want[38],
                     want[40:39]);
            $display("            got front=%h empty=%b count=%0d found=%b status=%0d fill=%h",
                     got[31:0], got[32], got[37:33], got[38], got[40:39], got[47:41]);
        end
    endfunction

    // Result checker. Every accepted result word is matched against the oldest
    // word owed; one with nothing owed is a fault of its own.
    always @(posedge clk)
    begin : watch_results
        logic [47:0] want_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (owed_q.size() == 0)
            begin
                flag_fault("result word with none pending", '0, m_axis_tdata);
            end
            else
            begin
                want_w = word_of(owed_q.pop_front());
                if (m_axis_tdata !== want_w)
                begin
                    flag_fault("result word mismatch", want_w, m_axis_tdata);
                end
            end
        end
    end

    // Result side back-pressure: stalls in random bursts while enabled.
    initial
    begin : result_side
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (rx_stall_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 15);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offers one command word from a falling edge, waits for the rising edge that
    // takes it, books the answer and returns at the next falling edge with tvalid
    // still high, so a following word goes out back to back.
    task automatic send_word(logic [1:0] cmd, fmtf_pkg::data_t val, bit typed,
                             fmtf_pkg::res_t typed_res);
        fmtf_pkg::res_t r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= cmd;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        r = apply_command(cmd, val);
        owed_q.push_back(typed ? typed_res : r);
        @(negedge clk);
    endtask

    task automatic idle_sender(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Values lean toward the extremes and a small pool, so moves find duplicates.
    function automatic fmtf_pkg::data_t pick_value();
        unique case ($urandom_range(0, 9))
            0:       return fmtf_pkg::data_t'(32'h8000_0000);
            1:       return fmtf_pkg::data_t'(32'h7FFF_FFFF);
            2:       return fmtf_pkg::data_t'(32'hFFFF_FFFF);
            3, 4, 5: return fmtf_pkg::data_t'(int'($urandom_range(0, 7)) - 3);
            default: return fmtf_pkg::data_t'($urandom);
        endcase
    endfunction

    // Most move keys are taken from the queue itself, at any position.
    function automatic fmtf_pkg::data_t pick_key();
        if (held_q.size() > 0 && $urandom_range(0, 9) < 7)
        begin
            return held_q[$urandom_range(0, held_q.size() - 1)];
        end
        return pick_value();
    endfunction

    // Traffic mix: lean 0 fills the queue, lean 1 drains it, lean 2 is balanced.
    function automatic logic [1:0] pick_command(int lean);
        int roll;
        int enq_pct;
        int deq_pct;
        roll    = $urandom_range(0, 99);
        enq_pct = (lean == 0) ? 60 : (lean == 1) ? 15 : 35;
        deq_pct = (lean == 0) ? 15 : (lean == 1) ? 60 : 30;
        if (roll < 3)
        begin
            return CMD_NOP;
        end
        else if (roll < 3 + enq_pct)
        begin
            return fmtf_pkg::CMD_ENQ;
        end
        else if (roll < 3 + enq_pct + deq_pct)
        begin
            return fmtf_pkg::CMD_DEQ;
        end
        return fmtf_pkg::CMD_MTF;
    endfunction

    initial
    begin : stimulus
        logic [1:0]      cmd;
        fmtf_pkg::data_t val;
        int              counted;
        int              total;
        int              lean;
        bit              tx_gaps;
        bit              quiet;
        int              i;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;

        // Directed table. Answers that are obvious from the command are typed in.
        add_step(fmtf_pkg::CMD_DEQ, 32'h0, 1,
                 result_of(32'h0, 1, 0, 0, fmtf_pkg::ST_EMPTY));
        add_step(fmtf_pkg::CMD_MTF, 32'h0, 1,
                 result_of(32'h0, 1, 0, 0, fmtf_pkg::ST_OK));
        add_step(CMD_NOP, 32'hFFFF_FFFF, 1,
                 result_of(32'h0, 1, 0, 0, fmtf_pkg::ST_OK));
        add_step(fmtf_pkg::CMD_ENQ, 32'h8000_0000, 1,
                 result_of(32'h8000_0000, 0, 1, 0, fmtf_pkg::ST_OK));
        // A single entry is never searched, even when it equals the key.
        add_step(fmtf_pkg::CMD_MTF, 32'h8000_0000, 1,
                 result_of(32'h8000_0000, 0, 1, 0, fmtf_pkg::ST_OK));
        add_step(fmtf_pkg::CMD_ENQ, 32'h7FFF_FFFF, 0, '0);
        add_step(fmtf_pkg::CMD_ENQ, 32'hFFFF_FFFF, 0, '0);
        add_step(fmtf_pkg::CMD_MTF, 32'h7FFF_FFFF, 0, '0);
        // Moving the back entry; the next enqueue shows whether the back moved too.
        add_step(fmtf_pkg::CMD_MTF, 32'hFFFF_FFFF, 0, '0);
        add_step(fmtf_pkg::CMD_ENQ, 32'h0, 0, '0);
        for (i = 0; i < 12; i++)
        begin
            add_step(fmtf_pkg::CMD_ENQ, fmtf_pkg::data_t'(32'h1 << i), 0, '0);
        end
        add_step(fmtf_pkg::CMD_ENQ, 32'h5555_5555, 1,
                 result_of(32'hFFFF_FFFF, 0, 16, 0, fmtf_pkg::ST_FULL));
        add_step(fmtf_pkg::CMD_MTF, 32'hFFFF_FFFF, 0, '0);    // key held only at the front
        add_step(fmtf_pkg::CMD_MTF, 32'h1234_5678, 0, '0);    // key absent
        add_step(fmtf_pkg::CMD_MTF, 32'h0000_0800, 0, '0);    // back entry of a full queue
        add_step(fmtf_pkg::CMD_DEQ, 32'h0, 0, '0);
        add_step(fmtf_pkg::CMD_ENQ, 32'hAAAA_AAAA, 0, '0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        rx_stall_on = 1'b1;
        foreach (dir_steps[k])
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                idle_sender($urandom_range(1, 16));
            end
            send_word(dir_steps[k].cmd, dir_steps[k].value, dir_steps[k].typed,
                      dir_steps[k].want);
        end

        // Random part. The mix and the idling change every PHASE_LEN commands, so
        // the queue swings between full and empty, and some phases run with no
        // idling on one side or both.
        counted = 0;
        total   = 0;
        lean    = 2;
        tx_gaps = 1'b0;
        while (counted < WORD_GOAL)
        begin
            quiet = (counted >= WORD_GOAL - QUIET_TAIL);
            if (total % PHASE_LEN == 0)
            begin
                lean        = $urandom_range(0, 2);
                tx_gaps     = ($urandom_range(0, 2) != 0);
                rx_stall_on = ($urandom_range(0, 2) != 0);
            end
            if (quiet)
            begin
                tx_gaps     = 1'b0;
                rx_stall_on = 1'b0;
            end
            cmd = pick_command(lean);
            val = (cmd == fmtf_pkg::CMD_MTF) ? pick_key() : pick_value();
            if (tx_gaps && $urandom_range(0, 5) == 0)
            begin
                idle_sender($urandom_range(1, 16));
            end
            send_word(cmd, val, 0, '0);
            if (cmd != CMD_NOP)
            begin
                counted++;
            end
            total++;
        end
        s_axis_tvalid <= 1'b0;

        // Wait for every owed word, then a while longer to catch stray extras.
        while (owed_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
        begin
            $display("fifo_with_move_to_front regression: pass");
        end
        else
        begin
            $display("fifo_with_move_to_front regression: fail");
        end
        $finish;
    end

endmodule

/* fifo_with_move_to_front.f */
src/fmtf_pkg.sv
src/fmtf_ram.sv
src/fmtf_seq.sv
src/fifo_with_move_to_front.sv
bench/fifo_with_move_to_front_tb.sv
